### design/cramer_solver_4x4_core_assert.svh
// Assertion macros shared by the solver modules
`ifndef CRAMER_SOLVER_4X4_CORE_ASSERT_SVH
`define CRAMER_SOLVER_4X4_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CS_ASSERT_IMP(label, clk, rst_n, a, c)
`define CS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### design/cs4_pkg.sv
package cs4_pkg;

    localparam int ORDER     = 4;
    localparam int ROW_LEN   = ORDER + 1;
    localparam int COEF_BITS = 12;
    localparam int FRAC_BITS = 16;
    localparam int X_BITS    = 48;
    localparam int DET_BITS  = 50;
    // numerator magnitude after fraction shift
    localparam int DIV_BITS  = DET_BITS + FRAC_BITS;
    localparam int DIV_STEPS = DIV_BITS;

    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_SOLVE = 1'b1
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic       mac_clear;  // clear accumulator, start term walk
        logic       mac_step;   // one product term accumulate
        logic [2:0] swap;       // replaced column, 4 = none
        logic       save_det;   // latch main determinant
        logic       div_start;
        logic       div_step;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mac_last;   // current step is the final term
        logic det_zero;
        logic div_last;
    } dp_sts_t;

endpackage

### design/cramer_solver_4x4_core.sv
// Cramer's rule solver for a 4x4 integer system. Load beats (cmd 0) write one
// coefficient each, a column above 4 being ignored. A solve beat (cmd 1)
// evaluates five determinants, each a 24-term sum walked one term per cycle
// through a shared two-stage multiplier, then four fixed-point divides on a
// restoring divider at one quotient bit per cycle, so a full solve holds input
// off until its last result is handed over; a singular matrix ends after the
// first determinant. Results leave through an output register, and a stalled
// output extends the solve.
module cramer_solver_4x4_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [0:0]         cmd,
    input  logic [1:0]         row,
    input  logic [2:0]         column,
    input  logic signed [11:0] coefficient,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         unknown_index,
    output logic signed [47:0] x_value,
    output logic               saturated,
    output logic               singular,
    output logic               last
);
    import cs4_pkg::*;

    dp_cmd_t    dcmd;
    dp_sts_t    dsts;
    logic       in_fire;
    logic       res_load, res_sing, res_last;
    logic [1:0] res_idx;
    logic [47:0] dp_x;
    logic       dp_sat;
    logic       out_taken;

    assign in_fire   = in_valid && in_ready;
    assign out_taken = out_valid && out_ready;

    cs4_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_solve  (cmd == CMD_SOLVE),
        .in_ready  (in_ready),
        .sts       (dsts),
        .cmd       (dcmd),
        .out_taken (out_taken),
        .res_load  (res_load),
        .res_sing  (res_sing),
        .res_idx   (res_idx),
        .res_last  (res_last),
        .res_busy  (out_valid && !out_ready)
    );

    cs4_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_en  (in_fire && (cmd == CMD_LOAD)),
        .load_row (row),
        .load_col (column),
        .load_val (coefficient),
        .cmd      (dcmd),
        .sts      (dsts),
        .x_value  (dp_x),
        .x_sat    (dp_sat)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            unknown_index <= res_idx;
            x_value       <= res_sing ? '0 : dp_x;
            saturated     <= res_sing ? 1'b0 : dp_sat;
            singular      <= res_sing;
            last          <= res_last;
        end
    end

endmodule

### design/cs4_datapath.sv
// Determinant and division datapath
module cs4_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load_en,
    input  logic [1:0]                  load_row,
    input  logic [2:0]                  load_col,
    input  logic signed [11:0]          load_val,
    input  cs4_pkg::dp_cmd_t            cmd,
    output cs4_pkg::dp_sts_t            sts,
    output logic [47:0]                 x_value,
    output logic                        x_sat
);
    import cs4_pkg::*;
    `include "cramer_solver_4x4_core_assert.svh"

    localparam int NTERMS = 24;

    // 20 entries, each read at fixed places: flops with async clear
    logic signed [COEF_BITS-1:0] store_reg [ORDER*ROW_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER*ROW_LEN; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (load_en && (load_col <= 3'(ORDER)))
        begin
            store_reg[5'(load_row) * 5'(ROW_LEN) + 5'(load_col)] <= load_val;
        end
    end

    // permutation table: the 24 terms of the Leibniz expansion
    function automatic logic [1:0] perm_col(input logic [4:0] t, input logic [1:0] r);
        logic [7:0] p;
        begin
            unique case (t)
                5'd0:  p = {2'd0, 2'd1, 2'd2, 2'd3};
                5'd1:  p = {2'd0, 2'd1, 2'd3, 2'd2};
                5'd2:  p = {2'd0, 2'd2, 2'd1, 2'd3};
                5'd3:  p = {2'd0, 2'd2, 2'd3, 2'd1};
                5'd4:  p = {2'd0, 2'd3, 2'd1, 2'd2};
                5'd5:  p = {2'd0, 2'd3, 2'd2, 2'd1};
                5'd6:  p = {2'd1, 2'd0, 2'd2, 2'd3};
                5'd7:  p = {2'd1, 2'd0, 2'd3, 2'd2};
                5'd8:  p = {2'd1, 2'd2, 2'd0, 2'd3};
                5'd9:  p = {2'd1, 2'd2, 2'd3, 2'd0};
                5'd10: p = {2'd1, 2'd3, 2'd0, 2'd2};
                5'd11: p = {2'd1, 2'd3, 2'd2, 2'd0};
                5'd12: p = {2'd2, 2'd0, 2'd1, 2'd3};
                5'd13: p = {2'd2, 2'd0, 2'd3, 2'd1};
                5'd14: p = {2'd2, 2'd1, 2'd0, 2'd3};
                5'd15: p = {2'd2, 2'd1, 2'd3, 2'd0};
                5'd16: p = {2'd2, 2'd3, 2'd0, 2'd1};
                5'd17: p = {2'd2, 2'd3, 2'd1, 2'd0};
                5'd18: p = {2'd3, 2'd0, 2'd1, 2'd2};
                5'd19: p = {2'd3, 2'd0, 2'd2, 2'd1};
                5'd20: p = {2'd3, 2'd1, 2'd0, 2'd2};
                5'd21: p = {2'd3, 2'd1, 2'd2, 2'd0};
                5'd22: p = {2'd3, 2'd2, 2'd0, 2'd1};
                5'd23: p = {2'd3, 2'd2, 2'd1, 2'd0};
                default: p = '0;
            endcase
            perm_col = p[7 - 2*int'(r) -: 2];
        end
    endfunction

    // odd permutations in table order
    localparam logic [NTERMS-1:0] ODD = 24'b0110_0110_0110_0110_0110_0110;

    logic [4:0]  term_reg;
    logic signed [DET_BITS-1:0] acc_reg;
    logic signed [DET_BITS-1:0] det_reg;
    logic signed [2*COEF_BITS-1:0] p01_reg, p23_reg;
    logic        pv_reg, psign_reg;
    logic signed [4*COEF_BITS-1:0] prod;

    // operand select through the permutation
    function automatic logic signed [COEF_BITS-1:0] pick(
        input logic [1:0] r, input logic [1:0] c, input logic [2:0] sw,
        input logic signed [COEF_BITS-1:0] st [ORDER*ROW_LEN]);
        logic [2:0] cc;
        begin
            cc = ({1'b0, c} == sw) ? 3'(ORDER) : {1'b0, c};
            pick = st[5'(r) * 5'(ROW_LEN) + 5'(cc)];
        end
    endfunction

    // stage one: two narrow products; stage two: their product into the sum
    assign prod = p01_reg * p23_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= '0;
            pv_reg   <= 1'b0;
            acc_reg  <= '0;
            det_reg  <= '0;
        end
        else
        begin
            pv_reg <= cmd.mac_step;
            if (cmd.mac_clear)
            begin
                term_reg <= '0;
                acc_reg  <= '0;
            end
            else
            begin
                if (cmd.mac_step)
                begin
                    term_reg <= term_reg + 5'd1;
                end
                if (pv_reg)
                begin
                    acc_reg <= psign_reg ? acc_reg - DET_BITS'(prod)
                                         : acc_reg + DET_BITS'(prod);
                end
            end
            if (cmd.save_det)
            begin
                det_reg <= acc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p01_reg   <= pick(2'd0, perm_col(term_reg, 2'd0), cmd.swap, store_reg)
                   * pick(2'd1, perm_col(term_reg, 2'd1), cmd.swap, store_reg);
        p23_reg   <= pick(2'd2, perm_col(term_reg, 2'd2), cmd.swap, store_reg)
                   * pick(2'd3, perm_col(term_reg, 2'd3), cmd.swap, store_reg);
        psign_reg <= ODD[term_reg];
    end

    assign sts.mac_last = (term_reg == 5'(NTERMS - 1));
    assign sts.det_zero = (acc_reg == '0);

    // restoring divider, one quotient bit per cycle
    logic [DIV_BITS-1:0] num_reg;
    logic [DET_BITS-1:0] den_reg;
    logic [DET_BITS:0]   rem_reg;
    logic [DIV_BITS-1:0] quo_reg;
    logic [6:0]          dcnt_reg;
    logic                neg_reg;
    logic [DET_BITS:0]   rem_sh;
    logic [DET_BITS:0]   rem_sub;

    assign rem_sh  = {rem_reg[DET_BITS-1:0], num_reg[DIV_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg <= {(acc_reg[DET_BITS-1] ? -acc_reg : acc_reg), {FRAC_BITS{1'b0}}};
            den_reg <= det_reg[DET_BITS-1] ? -det_reg : det_reg;
            neg_reg <= acc_reg[DET_BITS-1] ^ det_reg[DET_BITS-1];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[DIV_BITS-2:0], 1'b0};
            if (!rem_sub[DET_BITS])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    assign sts.div_last = (dcnt_reg == 7'(DIV_STEPS - 1));

    // sign and saturation
    localparam logic [DIV_BITS-1:0] POS_LIM = DIV_BITS'((66'd1 << (X_BITS-1)) - 66'd1);
    localparam logic [DIV_BITS-1:0] NEG_LIM = DIV_BITS'(66'd1 << (X_BITS-1));

    always_comb
    begin
        if (neg_reg)
        begin
            x_sat   = (quo_reg > NEG_LIM);
            x_value = x_sat ? NEG_LIM[X_BITS-1:0] : X_BITS'(-quo_reg);
        end
        else
        begin
            x_sat   = (quo_reg > POS_LIM);
            x_value = x_sat ? POS_LIM[X_BITS-1:0] : quo_reg[X_BITS-1:0];
        end
    end

    `CS_ASSERT_IMP(a_no_mix, clk, rst_n, cmd.mac_step, !cmd.div_step)
    `CS_ASSERT_NEXT(a_term_clr, clk, rst_n, cmd.mac_clear, term_reg == '0)
    `CS_ASSERT_NEXT(a_div_clr, clk, rst_n, cmd.div_start, dcnt_reg == '0)

endmodule

### design/cs4_ctrl.sv
// Solve sequencer
module cs4_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             in_solve,
    output logic             in_ready,
    input  cs4_pkg::dp_sts_t sts,
    output cs4_pkg::dp_cmd_t cmd,
    input  logic             out_taken,
    output logic             res_load,
    output logic             res_sing,
    output logic [1:0]       res_idx,
    output logic             res_last,
    input  logic             res_busy
);
    import cs4_pkg::*;
    `include "cramer_solver_4x4_core_assert.svh"

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MAC   = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_NEXT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] swap_reg, swap_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        swap_next     = swap_reg;
        cmd           = '0;
        cmd.swap      = swap_reg;
        res_load      = 1'b0;
        res_sing      = 1'b0;
        res_idx       = swap_reg[1:0];
        res_last      = (swap_reg == 3'(ORDER - 1));
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_solve)
                begin
                    swap_next     = 3'(ORDER);
                    cmd.mac_clear = 1'b1;
                    state_next    = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (sts.mac_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (swap_reg == 3'(ORDER))
                begin
                    cmd.save_det = 1'b1;
                    if (sts.det_zero)
                    begin
                        if (!res_busy)
                        begin
                            res_load   = 1'b1;
                            res_sing   = 1'b1;
                            res_idx    = 2'd0;
                            res_last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        swap_next     = 3'd0;
                        state_next    = S_NEXT;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_NEXT:
            begin
                cmd.mac_clear = 1'b1;
                state_next    = S_MAC;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!res_busy)
                begin
                    res_load = 1'b1;
                    if (swap_reg == 3'(ORDER - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        swap_next  = swap_reg + 3'd1;
                        state_next = S_NEXT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            swap_reg  <= 3'(ORDER);
        end
        else
        begin
            state_reg <= state_next;
            swap_reg  <= swap_next;
        end
    end

    `CS_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `CS_ASSERT_IMP(a_ready, clk, rst_n, in_ready, state_reg == S_IDLE)
    `CS_ASSERT_IMP(a_load_ok, clk, rst_n, res_load, !res_busy || out_taken)

endmodule

### verif/cramer_checker.sv
`timescale 1ns / 1ps

module cramer_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [0:0]         cmd,
    input  logic [1:0]         row,
    input  logic [2:0]         column,
    input  logic signed [11:0] coefficient,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         unknown_index,
    input  logic signed [47:0] x_value,
    input  logic               saturated,
    input  logic               singular,
    input  logic               last,
    output int                 fail_count,
    output int                 pending
);
    import cs4_pkg::*;

    typedef struct packed {
        logic [1:0]         idx;
        logic signed [47:0] x;
        logic               sat;
        logic               sing;
        logic               lst;
    } solution_t;

    // shadow of the coefficient store, A in columns 0..3, b in column 4
    logic signed [11:0] coef_shadow [ORDER][ROW_LEN];
    solution_t          solution_q [$];

    assign pending = solution_q.size();

    function automatic logic signed [63:0] det3(input logic signed [63:0] a [3][3]);
        return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
             - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
             + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
    endfunction

    // determinant with column swap_col replaced by b (swap_col 4 = plain A)
    function automatic logic signed [63:0] det4(input int swap_col);
        logic signed [63:0] m [4][4];
        logic signed [63:0] mnr [3][3];
        logic signed [63:0] acc;
        int cc;
        acc = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                m[i][j] = coef_shadow[i][(j == swap_col) ? ORDER : j];
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 1; r < 4; r++)
            begin
                cc = 0;
                for (int k = 0; k < 4; k++)
                    if (k != c)
                    begin
                        mnr[r-1][cc] = m[r][k];
                        cc++;
                    end
            end
            if (c[0]) acc = acc - m[0][c] * det3(mnr);
            else      acc = acc + m[0][c] * det3(mnr);
        end
        return acc;
    endfunction

    // fixed-point quotient, truncated toward zero, saturated to 48 bits
    function automatic void quotient(input logic signed [63:0] num,
                                     input logic signed [63:0] den,
                                     output logic [47:0] x, output logic sat);
        logic [127:0] a, d, q, cap;
        logic neg;
        a   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        q   = (a << FRAC_BITS) / d;
        cap = 128'd1 << (X_BITS - 1);
        sat = 1'b0;
        if (neg)
        begin
            if (q > cap) begin sat = 1'b1; x = cap[47:0]; end
            else x = 48'(-q);
        end
        else
        begin
            if (q > cap - 1) begin sat = 1'b1; x = cap[47:0] - 48'd1; end
            else x = q[47:0];
        end
    endfunction

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [63:0] dmain;
        solution_t s, e;
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
                for (int j = 0; j < ROW_LEN; j++)
                    coef_shadow[i][j] = '0;
        end
        else
        begin
            // input beat: update store or predict solution
            if (in_valid && in_ready)
            begin
                if (cmd == CMD_LOAD)
                begin
                    if (column <= ORDER) coef_shadow[row][column] = coefficient;
                end
                else
                begin
                    dmain = det4(ORDER);
                    if (dmain == 0)
                        solution_q.push_back('{2'd0, 48'sd0, 1'b0, 1'b1, 1'b1});
                    else
                        for (int k = 0; k < ORDER; k++)
                        begin
                            s.idx  = 2'(k);
                            s.sing = 1'b0;
                            s.lst  = (k == ORDER - 1);
                            quotient(det4(k), dmain, s.x, s.sat);
                            solution_q.push_back(s);
                        end
                end
            end
            // result beat
            if (out_valid && out_ready)
            begin
                if (solution_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    e = solution_q.pop_front();
                    if (unknown_index !== e.idx)
                        report($sformatf("index %0d exp %0d", unknown_index, e.idx));
                    if (x_value !== e.x)
                        report($sformatf("x[%0d] %0d exp %0d", e.idx, x_value, e.x));
                    if (saturated !== e.sat)
                        report($sformatf("saturated %0b exp %0b", saturated, e.sat));
                    if (singular !== e.sing)
                        report($sformatf("singular %0b exp %0b", singular, e.sing));
                    if (last !== e.lst)
                        report($sformatf("last %0b exp %0b", last, e.lst));
                end
            end
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cs4_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [0:0]         cmd;
    logic [1:0]         row;
    logic [2:0]         column;
    logic signed [11:0] coefficient;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         unknown_index;
    logic signed [47:0] x_value;
    logic               saturated;
    logic               singular;
    logic               last;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    cramer_solver_4x4_core u_dut (.*);

    cramer_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_beat(input cmd_t c, input logic [1:0] r, input logic [2:0] col,
                             input logic signed [11:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        row         <= r;
        column      <= col;
        coefficient <= v;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic signed [11:0] rand_coef(input int span);
        case ($urandom_range(9))
            0: return 12'sh800;
            1: return 12'sh7FF;
            2: return 12'sd0;
            default: return $signed(12'($urandom_range(2 * span))) - 12'(span);
        endcase
    endfunction

    // system load with coefficients skipped at random, followed by a solve; span keeps most systems well conditioned
    task automatic load_and_solve(input int span);
        for (int r = 0; r < ORDER; r++)
            for (int c = 0; c < ROW_LEN; c++)
                if ($urandom_range(9) != 0)
                    send_beat(CMD_LOAD, 2'(r), 3'(c), rand_coef(span));
        if ($urandom_range(3) == 0)
            send_beat(CMD_LOAD, 2'($urandom_range(3)), 3'($urandom_range(7, 5)),
                      12'($urandom));
        send_beat(CMD_SOLVE, 2'($urandom_range(3)), 3'($urandom_range(7)), 12'($urandom));
    endtask

    // drop in_valid, let the last accepted solve be predicted, then wait until no results are pending
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        int spans [4] = '{2, 20, 300, 2048};
        rst_n = 1'b0; in_valid = 1'b0; cmd = CMD_LOAD; row = '0; column = '0;
        coefficient = '0; send_idle_pct = 0; recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // solve before any load: zero matrix
        send_beat(CMD_SOLVE, 2'd3, 3'd7, 12'sh7FF);
        // identity with extreme b
        for (int r = 0; r < ORDER; r++)
            for (int c = 0; c < ORDER; c++)
                send_beat(CMD_LOAD, 2'(r), 3'(c), (r == c) ? 12'sd1 : 12'sd0);
        send_beat(CMD_LOAD, 2'd0, 3'd4, 12'sh7FF);
        send_beat(CMD_LOAD, 2'd1, 3'd4, 12'sh800);
        send_beat(CMD_LOAD, 2'd2, 3'd4, -12'sd1);
        send_beat(CMD_LOAD, 2'd3, 3'd4, 12'sd0);
        send_beat(CMD_LOAD, 2'd0, 3'd5, 12'sh555);   // column out of range, ignored
        send_beat(CMD_SOLVE, 2'd0, 3'd0, 12'sd0);
        // det = 1 with huge numerators is unreachable; a[3][3] = -2048 gives det(A) = -2048
        send_beat(CMD_LOAD, 2'd3, 3'd3, 12'sh800);
        send_beat(CMD_SOLVE, 2'd0, 3'd0, 12'sd0);
        // zero a row: singular
        send_beat(CMD_LOAD, 2'd0, 3'd0, 12'sd0);
        send_beat(CMD_SOLVE, 2'd0, 3'd0, 12'sd0);
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 68 : (ph == 3) ? 19 : 0;
            recv_stall_pct = (ph == 2) ? 68 : (ph == 3) ? 19 : 0;
            for (int n = 0; n < 2; n++)
            begin
                load_and_solve(spans[$urandom_range(3)]);
                if (n == 0) drain();   // sender waits for all results
            end
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        // single-coefficient perturbations between solves
        for (int n = 0; n < 4; n++)
        begin
            send_beat(CMD_LOAD, 2'($urandom_range(3)), 3'($urandom_range(4)),
                      rand_coef(2048));
            send_beat(CMD_SOLVE, 2'd0, 3'd0, 12'sd0);
        end
        drain();

        if (fail_count == 0)
            $display("cramer_solver_4x4_core test passed");
        else
            $display("cramer_solver_4x4_core test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("cramer_solver_4x4_core test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/cs4_pkg.sv
design/cs4_datapath.sv
design/cs4_ctrl.sv
design/cramer_solver_4x4_core.sv
verif/cramer_checker.sv
verif/testbench.sv
